[rtl/hsc_pkg.sv]
// hsc_pkg: shared types, constants and table functions for the hall commutator
`timescale 1ns / 1ps
package hsc_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  localparam logic [7:0] KEY_REVERSE = 8'h6C;
  localparam logic [7:0] KEY_FORWARD = 8'h70;
  localparam logic [7:0] KEY_COMMIT  = 8'h65;
  localparam logic [7:0] KEY_DIGIT0  = 8'h30;
  localparam logic [7:0] KEY_DIGIT9  = 8'h39;

  localparam logic [15:0] TIMER_TOP = 16'hFFFF;
  localparam logic [15:0] ENTRY_MIN = 16'd100;
  localparam logic [15:0] ENTRY_MAX = 16'd500;

  localparam int DIVIDEND_W = 20;
  localparam logic [DIVIDEND_W-1:0] DIVIDEND = 20'd1000000;
  localparam int DIVISOR_W = 9;
  localparam int DIV_STEPS = DIVIDEND_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [2:0] SECTOR_FIRST = 3'd0;
  localparam logic [2:0] SECTOR_LAST  = 3'd5;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_load;
  } hsc_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
  } hsc_status_t;

  function automatic logic [7:0] drive_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'hDE;
      3'd1: b = 8'hDB;
      3'd2: b = 8'hF9;
      3'd3: b = 8'hED;
      3'd4: b = 8'hE7;
      3'd5: b = 8'hF6;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // returns {match, sector}
  function automatic logic [3:0] hall_sector(input logic [2:0] hall);
    logic [3:0] r;
    case (hall)
      3'd3: r = {1'b1, 3'd0};
      3'd1: r = {1'b1, 3'd1};
      3'd5: r = {1'b1, 3'd2};
      3'd4: r = {1'b1, 3'd3};
      3'd6: r = {1'b1, 3'd4};
      3'd2: r = {1'b1, 3'd5};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/hall_commutator_with_speed_entry_core.sv]
// hall_commutator_with_speed_entry_core: six-step commutator top level
//
//   channel | handshake           | beat contents
//   --------+---------------------+-------------------------------------------------
//   in      | in_valid / in_ready | operation, key_code, hall_code
//   out     | out_valid/out_ready | drive_update, drive_pattern, period_accepted,
//           |                     | reload_value
//
// ticks and keys that start no division give one beat per cycle while out is taken
// a commit key with an entry of 100 to 500 loads the entry as divisor, then the
// bit-serial divider of 1000000 by the entry runs, then the result loads
// in_ready is low while a division runs or while an unread result blocks the output
// synchronous reset clears all state but the divider; no beat is pending after reset
`timescale 1ns / 1ps
module hall_commutator_with_speed_entry_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  key_code,
  input  logic [2:0]  hall_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        drive_update,
  output logic [7:0]  drive_pattern,
  output logic        period_accepted,
  output logic [15:0] reload_value
);
  import hsc_pkg::*;

  hsc_cmd_t    cmd;
  hsc_status_t status;

  hsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  hsc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .operation       (operation),
    .key_code        (key_code),
    .hall_code       (hall_code),
    .drive_update    (drive_update),
    .drive_pattern   (drive_pattern),
    .period_accepted (period_accepted),
    .reload_value    (reload_value)
  );

endmodule

[rtl/hsc_datapath.sv]
// hsc_datapath: timer, key entry, sector state and serial divider
`timescale 1ns / 1ps
module hsc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  hsc_pkg::hsc_cmd_t    cmd,
  output hsc_pkg::hsc_status_t status,
  input  logic                operation,
  input  logic [7:0]          key_code,
  input  logic [2:0]          hall_code,
  output logic                drive_update,
  output logic [7:0]          drive_pattern,
  output logic                period_accepted,
  output logic [15:0]         reload_value
);
  import hsc_pkg::*;

  logic [15:0] tick_counter, tick_counter_next;
  logic [15:0] reload_register;
  logic [15:0] entry_number, entry_number_next;
  logic        direction_forward, direction_forward_next;
  logic [2:0]  sector_index, sector_index_next;
  logic [7:0]  pattern_hold, pattern_hold_next;
  logic        fire_next;

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  acc;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [DIVISOR_W:0]    trial;
  logic                  trial_ge;

  logic [3:0] hit;
  logic [2:0] sec;

  assign status.needs_div = (operation == OP_KEY) && (key_code == KEY_COMMIT) &&
                            (entry_number >= ENTRY_MIN) && (entry_number <= ENTRY_MAX);
  assign status.div_done  = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  assign trial    = {acc, quo[DIVIDEND_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  always_comb begin
    tick_counter_next      = tick_counter;
    entry_number_next      = entry_number;
    direction_forward_next = direction_forward;
    sector_index_next      = sector_index;
    pattern_hold_next      = pattern_hold;
    fire_next              = 1'b0;
    hit                    = hall_sector(hall_code);
    sec                    = hit[3] ? hit[2:0] : sector_index;
    if (operation == OP_TICK) begin
      if (tick_counter == TIMER_TOP) begin
        tick_counter_next = reload_register;
        fire_next         = 1'b1;
        sector_index_next = sec;
        if (direction_forward) begin
          if (sec >= SECTOR_LAST) begin
            sector_index_next = SECTOR_FIRST;
            pattern_hold_next = drive_byte(SECTOR_FIRST);
          end else begin
            pattern_hold_next = drive_byte(sec + 3'd1);
          end
        end else begin
          if (sec == SECTOR_FIRST) begin
            sector_index_next = SECTOR_LAST;
            pattern_hold_next = drive_byte(SECTOR_LAST);
          end else if (sec > SECTOR_LAST) begin
            pattern_hold_next = drive_byte(SECTOR_LAST);
          end else begin
            pattern_hold_next = drive_byte(sec - 3'd1);
          end
        end
      end else begin
        tick_counter_next = tick_counter + 16'd1;
      end
    end else begin
      case (key_code) inside
        KEY_REVERSE: direction_forward_next = 1'b0;
        KEY_FORWARD: direction_forward_next = 1'b1;
        [KEY_DIGIT0:KEY_DIGIT9]:
          entry_number_next = (entry_number << 3) + (entry_number << 1) +
                              {12'd0, key_code[3:0]};
        KEY_COMMIT: entry_number_next = 16'd0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter      <= 16'd0;
      reload_register   <= 16'd0;
      entry_number      <= 16'd0;
      direction_forward <= 1'b0;
      sector_index      <= 3'd0;
      pattern_hold      <= 8'd0;
      drive_update      <= 1'b0;
      period_accepted   <= 1'b0;
      div_cnt           <= '0;
    end else begin
      if (cmd.accept) begin
        tick_counter      <= tick_counter_next;
        entry_number      <= entry_number_next;
        direction_forward <= direction_forward_next;
        sector_index      <= sector_index_next;
        pattern_hold      <= pattern_hold_next;
        drive_update      <= fire_next;
        period_accepted   <= 1'b0;
        div_cnt           <= '0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.div_load) begin
        reload_register <= TIMER_TOP - quo[15:0];
        drive_update    <= 1'b0;
        period_accepted <= 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      quo     <= DIVIDEND;
      acc     <= '0;
      divisor <= entry_number[DIVISOR_W-1:0];
    end else if (cmd.div_step) begin
      quo <= {quo[DIVIDEND_W-2:0], trial_ge};
      acc <= trial_ge ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
    end
  end

  assign drive_pattern = pattern_hold;
  assign reload_value  = reload_register;

endmodule

[rtl/hsc_ctrl.sv]
// hsc_ctrl: handshake and sequencing state machine
`timescale 1ns / 1ps
module hsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output hsc_pkg::hsc_cmd_t    cmd,
  input  hsc_pkg::hsc_status_t status
);
  import hsc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.accept     = 1'b0;
    cmd.div_step   = 1'b0;
    cmd.div_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (status.needs_div) begin
            state_next = ST_DIVIDE;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.div_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
